### hw/rtl/ctt_pkg.sv
// Shared types and constants for the cooperative task timer table.
// Used by the controller, the datapath and the top level; no dependencies.
package ctt_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_DISP = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY_DEL = 2'd2;

	localparam logic [7:0] PENDING_MAX = 8'd255;

	typedef logic [2:0] res_kind_t;
	localparam res_kind_t RES_NONE = 3'd0;
	localparam res_kind_t RES_ADD  = 3'd1;
	localparam res_kind_t RES_FULL = 3'd2;
	localparam res_kind_t RES_DEL  = 3'd3;
	localparam res_kind_t RES_HIT  = 3'd4;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  pending;
	} ctt_entry_t;

	typedef struct packed {
		logic      capture;
		logic      scan;
		logic      inc;
		logic      tick_wr;
		logic      disp_take;
		logic      add_put;
		logic      del_do;
		logic      res_load;
		res_kind_t res_kind;
	} ctt_cmd_t;

	typedef struct packed {
		logic at_end;
		logic hit;
		logic free_here;
		logic tag_zero;
	} ctt_stat_t;

endpackage

### hw/rtl/ctt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ctt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/ctt_ctrl.sv
// Controller state machine for the task timer table: sequences the slot walk per operation.
// Depends on ctt_pkg; drives ctt_datapath through ctt_cmd_t, reads ctt_stat_t back.
module ctt_ctrl
	import ctt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [1:0] op,
	input  ctt_stat_t stat,
	output ctt_cmd_t  cmd,
	output logic      busy
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TICK = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_DEL  = 3'd3;
	localparam logic [2:0] S_DISP = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (op)
						OP_TICK: state_d = S_TICK;
						OP_ADD:  state_d = S_ADD;
						OP_DEL:  state_d = S_DEL;
						default: state_d = S_DISP;
					endcase
				end
			end
			S_TICK: begin
				cmd.scan    = 1'b1;
				cmd.inc     = 1'b1;
				cmd.tick_wr = 1'b1;
				if (stat.at_end) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_NONE;
					state_d      = S_IDLE;
				end
			end
			S_DISP: begin
				cmd.scan = 1'b1;
				cmd.inc  = 1'b1;
				if (stat.hit) begin
					cmd.disp_take = 1'b1;
					cmd.res_load  = 1'b1;
					cmd.res_kind  = RES_HIT;
					state_d       = S_IDLE;
				end else if (stat.at_end) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_NONE;
					state_d      = S_IDLE;
				end
			end
			S_ADD: begin
				if (stat.tag_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_NONE;
					state_d      = S_IDLE;
				end else if (stat.free_here) begin
					cmd.add_put  = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ADD;
					state_d      = S_IDLE;
				end else if (stat.at_end) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d      = S_IDLE;
				end else begin
					cmd.inc = 1'b1;
				end
			end
			S_DEL: begin
				cmd.del_do   = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_DEL;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### hw/rtl/ctt_datapath.sv
// Datapath for the task timer table: slot RAM, occupancy bits, walk counter, result registers.
// Depends on ctt_pkg and ctt_ram; commanded by ctt_ctrl.
module ctt_datapath
	import ctt_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctt_cmd_t    cmd,
	output ctt_stat_t   stat,
	input  logic [7:0]  task_tag,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [2:0]  slot_select,
	output logic        done,
	output logic [3:0]  slot_index,
	output logic        run_valid,
	output logic [7:0]  run_tag,
	output logic [1:0]  status,
	output logic [1:0]  last_error
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = (IW > 3) ? IW + 1 : 4;
	localparam logic [3:0] NONE_IDX = 4'(SLOTS);

	// captured transaction
	logic [7:0]  tag_q;
	logic [15:0] dly_q;
	logic [15:0] per_q;
	logic [2:0]  sel_q;

	logic [CW-1:0]    cnt_q;
	logic [SLOTS-1:0] valid_q;
	logic [1:0]       error_q;

	// read pipeline stage
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic          cnt_lt;
	logic [IW-1:0] cnt_idx;
	ctt_entry_t    rd_entry;
	logic          occ_s1;
	logic          we;
	logic [IW-1:0] waddr;
	ctt_entry_t    wdata;
	ctt_entry_t    tick_entry;
	logic [SW-1:0] sel_w;
	logic          sel_in;
	logic          del_hit;

	logic [3:0] slot_d;
	logic       run_valid_d;
	logic [7:0] run_tag_d;
	logic [1:0] status_d;
	logic [1:0] error_d;

	assign cnt_lt  = (cnt_q < CW'(SLOTS));
	assign cnt_idx = cnt_q[IW-1:0];
	assign occ_s1  = valid_q[idx_s1];
	assign sel_w   = SW'(sel_q);
	assign sel_in  = (sel_w < SW'(SLOTS));
	assign del_hit = sel_in && valid_q[sel_w[IW-1:0]];

	assign stat.at_end    = (cnt_q == CW'(SLOTS));
	assign stat.hit       = vld_s1 && occ_s1 && (rd_entry.pending != 8'd0);
	assign stat.free_here = cnt_lt && !valid_q[cnt_idx];
	assign stat.tag_zero  = (tag_q == 8'd0);

	ctt_ram #(
		.WIDTH($bits(ctt_entry_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(cnt_idx),
		.rdata(rd_entry)
	);

	// age one slot: due slots gain a pending run and periodic ones reload, others count down
	always_comb begin
		tick_entry = rd_entry;
		if (rd_entry.delay == 16'd0) begin
			if (rd_entry.pending != PENDING_MAX) begin
				tick_entry.pending = rd_entry.pending + 8'd1;
			end
			if (rd_entry.period != 16'd0) begin
				tick_entry.delay = rd_entry.period;
			end
		end else begin
			tick_entry.delay = rd_entry.delay - 16'd1;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = tick_entry;
		if (cmd.tick_wr && vld_s1 && occ_s1) begin
			we = 1'b1;
		end else if (cmd.disp_take && (rd_entry.period != 16'd0)) begin
			we            = 1'b1;
			wdata         = rd_entry;
			wdata.pending = rd_entry.pending - 8'd1;
		end else if (cmd.add_put) begin
			we    = 1'b1;
			waddr = cnt_idx;
			wdata = '{tag: tag_q, delay: dly_q, period: per_q, pending: 8'd0};
		end
	end

	always_comb begin
		slot_d      = NONE_IDX;
		run_valid_d = 1'b0;
		run_tag_d   = 8'd0;
		status_d    = ST_OK;
		error_d     = error_q;
		case (cmd.res_kind)
			RES_ADD: begin
				slot_d = 4'(cnt_q);
			end
			RES_HIT: begin
				slot_d      = 4'(idx_s1);
				run_valid_d = 1'b1;
				run_tag_d   = rd_entry.tag;
			end
			RES_FULL: begin
				status_d = ST_FULL;
				error_d  = ST_FULL;
			end
			RES_DEL: begin
				if (!del_hit) begin
					status_d = ST_EMPTY_DEL;
					error_d  = ST_EMPTY_DEL;
				end
			end
			default: begin
				slot_d = NONE_IDX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_q <= task_tag;
			dly_q <= start_delay;
			per_q <= repeat_period;
			sel_q <= slot_select;
		end
		idx_s1 <= cnt_idx;
		if (cmd.res_load) begin
			slot_index <= slot_d;
			run_valid  <= run_valid_d;
			run_tag    <= run_tag_d;
			status     <= status_d;
			last_error <= error_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			valid_q <= '0;
			error_q <= ST_OK;
			done    <= 1'b0;
		end else begin
			done   <= cmd.res_load;
			vld_s1 <= cmd.scan && cnt_lt;
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.inc && cnt_lt) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.res_load) begin
				error_q <= error_d;
			end
			if (cmd.add_put) begin
				valid_q[cnt_idx] <= 1'b1;
			end
			if (cmd.del_do && sel_in) begin
				valid_q[sel_w[IW-1:0]] <= 1'b0;
			end
			// drop a one-shot task once its run is handed out
			if (cmd.disp_take && (rd_entry.period == 16'd0)) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	a_run_has_tag: assert property (@(posedge clk) disable iff (!arst_n)
		done && run_valid |-> run_tag != 8'd0)
		else $error("dispatched task carries tag zero");

	a_full_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> last_error == status)
		else $error("error code not latched");

	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_put |=> valid_q[$past(cnt_idx)])
		else $error("added slot not marked occupied");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		error_q != 2'd3)
		else $error("undefined error code");

endmodule

### hw/rtl/cooperative_task_timer_table_top.sv
// Cooperative task timer table: SLOTS task slots aged by tick, filled by add, served by dispatch.
// Tick walks the slot RAM one slot a cycle and strobes done after the walk passes the last slot.
// Add stops at the first free slot and dispatch at the first slot with a pending run;
// delete acts on the selected slot without a walk.
// start is taken again in the cycle done strobes; the receiver cannot stall results.
// Asynchronous active-low reset empties every slot and clears sticky error_q at once; last_error holds.
module cooperative_task_timer_table_top
	import ctt_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  task_tag,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [2:0]  slot_select,
	output logic        done,
	output logic [3:0]  slot_index,
	output logic        run_valid,
	output logic [7:0]  run_tag,
	output logic [1:0]  status,
	output logic [1:0]  last_error
);

	ctt_cmd_t  cmd;
	ctt_stat_t stat;

	ctt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	ctt_datapath #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.task_tag     (task_tag),
		.start_delay  (start_delay),
		.repeat_period(repeat_period),
		.slot_select  (slot_select),
		.done         (done),
		.slot_index   (slot_index),
		.run_valid    (run_valid),
		.run_tag      (run_tag),
		.status       (status),
		.last_error   (last_error)
	);

endmodule
